// ===== rtl/core/pawa_pkg.sv =====
// types, constants and codes shared by the paged access block
package pawa_pkg;

    // geometry of the virtual space and of the frame store
    localparam int PAGE_WORDS  = 8;
    localparam int NUM_PAGES   = 32;
    localparam int NUM_FRAMES  = 16;
    localparam int STORE_WORDS = NUM_FRAMES * PAGE_WORDS;

    localparam int OFFS_W  = $clog2(PAGE_WORDS);
    localparam int PAGE_W  = $clog2(NUM_PAGES);
    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam int LOC_W   = $clog2(STORE_WORDS);

    // fixed field widths
    localparam int FUNC_W  = 3;
    localparam int ADDR_W  = 12;
    localparam int DATA_W  = 32;
    localparam int PNUM_W  = 5;
    localparam int FNUM_W  = 4;
    localparam int AGE_W   = 8;
    localparam int CNT_W   = 16;
    localparam int VPAGE_W = ADDR_W - OFFS_W;

    // function codes
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSTALL = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_QUERY   = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGING_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_INTERVAL = 1'd1;
    localparam logic [CNT_W-1:0]     AGE_INTERVAL_RST = 16'd20;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [ADDR_W-1:0]        address;
        logic signed [DATA_W-1:0] write_data;
        logic [PNUM_W-1:0]        page_idx;
        logic [FNUM_W-1:0]        frame_number;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic                     fault;
        logic [PNUM_W-1:0]        fault_page;
        logic                     range_error;
        logic                     entry_valid;
        logic                     entry_ref;
        logic                     entry_dirty;
        logic [AGE_W-1:0]         entry_age;
        logic                     aged;
    } out_item_t;

    typedef struct packed {
        logic             aging_enable;
        logic [CNT_W-1:0] age_interval;
    } cfg_t;

    // one page table word
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               ref_mark;
        logic               dirty;
        logic [AGE_W-1:0]   age;
    } pt_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_READ_WAIT,
        ST_INSTALL,
        ST_ENTRY,
        ST_RESP,
        ST_SWEEP,
        ST_SWEEP_LAST
    } state_t;

endpackage

// ===== rtl/core/paged_access_with_aging_core.sv =====
// top level of the paged access block with aging reference marks
// Translates a virtual word address through a 32-entry page table into a 16-frame, 128-word
// store and reads or writes one word per transaction, and also serves install, remove and query
// transactions on the page table. A fault or a range error reaches the result register from
// ST_RESP, a write from ST_ACCESS, an install from ST_INSTALL, a remove or query from ST_ENTRY,
// and a read from ST_READ_WAIT, since the data ram read follows the page table read, both rams
// having a registered read. The block takes no new transaction until it has registered the
// result of the last one; a stalled result holds the block for as long. When an access
// completes an aging interval with aging enabled, a sweep of the page table follows the result
// and holds off new transactions, one entry read and one written back each cycle. Configuration
// is written through cfg_valid/cfg_ready, which is always ready, and must only be written while
// no transaction is in flight.
module paged_access_with_aging_core
    import pawa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  in_item_t             req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output out_item_t            rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    logic              aging_enable_reg;
    logic [CNT_W-1:0]  age_interval_reg;
    cfg_t              cfg;

    logic               pt_rd_en;
    logic [PAGE_W-1:0]  pt_rd_addr;
    pt_entry_t          pt_rd_data;
    logic               pt_wr_en;
    logic [PAGE_W-1:0]  pt_wr_addr;
    pt_entry_t          pt_wr_data;
    logic               own_rd_en;
    logic [FRAME_W-1:0] own_rd_addr;
    logic [PAGE_W-1:0]  own_rd_data;
    logic               own_wr_en;
    logic [FRAME_W-1:0] own_wr_addr;
    logic [PAGE_W-1:0]  own_wr_data;
    logic               dat_rd_en;
    logic [LOC_W-1:0]   dat_rd_addr;
    logic [DATA_W-1:0]  dat_rd_data;
    logic               dat_wr_en;
    logic [LOC_W-1:0]   dat_wr_addr;
    logic [DATA_W-1:0]  dat_wr_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aging_enable_reg <= 1'b0;
            age_interval_reg <= AGE_INTERVAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_AGING_ENABLE)
            begin
                aging_enable_reg <= cfg_data[0];
            end
            if (cfg_index == CFG_AGE_INTERVAL)
            begin
                age_interval_reg <= cfg_data;
            end
        end
    end

    assign cfg.aging_enable = aging_enable_reg;
    assign cfg.age_interval = age_interval_reg;

    pawa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .pt_rd_en    (pt_rd_en),
        .pt_rd_addr  (pt_rd_addr),
        .pt_rd_data  (pt_rd_data),
        .pt_wr_en    (pt_wr_en),
        .pt_wr_addr  (pt_wr_addr),
        .pt_wr_data  (pt_wr_data),
        .own_rd_en   (own_rd_en),
        .own_rd_addr (own_rd_addr),
        .own_rd_data (own_rd_data),
        .own_wr_en   (own_wr_en),
        .own_wr_addr (own_wr_addr),
        .own_wr_data (own_wr_data),
        .dat_rd_en   (dat_rd_en),
        .dat_rd_addr (dat_rd_addr),
        .dat_rd_data (dat_rd_data),
        .dat_wr_en   (dat_wr_en),
        .dat_wr_addr (dat_wr_addr),
        .dat_wr_data (dat_wr_data)
    );

    // page table: frame, reference and dirty marks, age
    pawa_ram #(
        .WIDTH ($bits(pt_entry_t)),
        .DEPTH (NUM_PAGES)
    ) u_page_table (
        .clk     (clk),
        .wr_en   (pt_wr_en),
        .wr_addr (pt_wr_addr),
        .wr_data (pt_wr_data),
        .rd_en   (pt_rd_en),
        .rd_addr (pt_rd_addr),
        .rd_data (pt_rd_data)
    );

    // owning page of each frame
    pawa_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_FRAMES)
    ) u_frame_owner (
        .clk     (clk),
        .wr_en   (own_wr_en),
        .wr_addr (own_wr_addr),
        .wr_data (own_wr_data),
        .rd_en   (own_rd_en),
        .rd_addr (own_rd_addr),
        .rd_data (own_rd_data)
    );

    // frame store
    pawa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_WORDS)
    ) u_data_store (
        .clk     (clk),
        .wr_en   (dat_wr_en),
        .wr_addr (dat_wr_addr),
        .wr_data (dat_wr_data),
        .rd_en   (dat_rd_en),
        .rd_addr (dat_rd_addr),
        .rd_data (dat_rd_data)
    );

endmodule

// ===== rtl/core/pawa_ram.sv =====
// generic simple dual port ram with registered read
module pawa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/pawa_ctrl.sv =====
// sequencer: translation, page table upkeep, aging sweep and result register
module pawa_ctrl
    import pawa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                req_valid,
    output logic                req_stall,
    input  in_item_t            req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output out_item_t           rsp,
    output logic                pt_rd_en,
    output logic [PAGE_W-1:0]   pt_rd_addr,
    input  pt_entry_t           pt_rd_data,
    output logic                pt_wr_en,
    output logic [PAGE_W-1:0]   pt_wr_addr,
    output pt_entry_t           pt_wr_data,
    output logic                own_rd_en,
    output logic [FRAME_W-1:0]  own_rd_addr,
    input  logic [PAGE_W-1:0]   own_rd_data,
    output logic                own_wr_en,
    output logic [FRAME_W-1:0]  own_wr_addr,
    output logic [PAGE_W-1:0]   own_wr_data,
    output logic                dat_rd_en,
    output logic [LOC_W-1:0]    dat_rd_addr,
    input  logic [DATA_W-1:0]   dat_rd_data,
    output logic                dat_wr_en,
    output logic [LOC_W-1:0]    dat_wr_addr,
    output logic [DATA_W-1:0]   dat_wr_data
);

    state_t                  state_reg, state_next;
    in_item_t                item_reg, item_next;
    out_item_t               res_reg, res_next;
    out_item_t               rsp_reg, rsp_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    aged_reg, aged_next;
    logic [CNT_W-1:0]        counter_reg, counter_next;
    logic [NUM_PAGES-1:0]    valid_reg, valid_next;
    logic [NUM_PAGES-1:0]    init_reg, init_next;
    logic [NUM_FRAMES-1:0]   owned_reg, owned_next;
    logic [PAGE_W-1:0]       sweep_idx_reg, sweep_idx_next;
    logic                    pend_reg, pend_next;
    logic [PAGE_W-1:0]       pend_idx_reg, pend_idx_next;

    logic [VPAGE_W-1:0]      vpage_in;
    logic                    vpage_in_range;
    logic [VPAGE_W-1:0]      vpage_cur;
    logic [PAGE_W-1:0]       vidx;
    logic [PAGE_W-1:0]       pidx;
    logic [FRAME_W-1:0]      fidx;
    logic                    out_free;
    logic [CNT_W:0]          cnt_inc;
    logic                    cnt_hit;
    logic                    aged_now;
    logic                    old_valid;
    logic                    own_taken;
    pt_entry_t               ent;
    logic                    emit;
    out_item_t               emit_item;

    assign vpage_in       = req.address[ADDR_W-1:OFFS_W];
    assign vpage_in_range = int'(vpage_in) < NUM_PAGES;
    assign vpage_cur      = item_reg.address[ADDR_W-1:OFFS_W];
    assign vidx           = vpage_cur[PAGE_W-1:0];
    assign pidx           = item_reg.page_idx[PAGE_W-1:0];
    assign fidx           = item_reg.frame_number[FRAME_W-1:0];
    assign out_free       = !rsp_valid_reg || !rsp_stall;

    // access counter, an interval of zero behaves as one
    assign cnt_inc  = {1'b0, counter_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign cnt_hit  = cnt_inc >= {1'b0, cfg.age_interval};
    assign aged_now = cnt_hit && cfg.aging_enable;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            aged_reg      <= 1'b0;
            counter_reg   <= '0;
            valid_reg     <= '0;
            init_reg      <= '0;
            owned_reg     <= '0;
            sweep_idx_reg <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            aged_reg      <= aged_next;
            counter_reg   <= counter_next;
            valid_reg     <= valid_next;
            init_reg      <= init_next;
            owned_reg     <= owned_next;
            sweep_idx_reg <= sweep_idx_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        aged_next      = aged_reg;
        counter_next   = counter_reg;
        valid_next     = valid_reg;
        init_next      = init_reg;
        owned_next     = owned_reg;
        sweep_idx_next = sweep_idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        req_stall   = state_reg != ST_IDLE;
        pt_rd_en    = 1'b0;
        pt_rd_addr  = pidx;
        pt_wr_en    = 1'b0;
        pt_wr_addr  = pidx;
        pt_wr_data  = pt_rd_data;
        own_rd_en   = 1'b0;
        own_rd_addr = fidx;
        own_wr_en   = 1'b0;
        own_wr_addr = fidx;
        own_wr_data = pidx;
        dat_rd_en   = 1'b0;
        dat_rd_addr = {pt_rd_data.frame, item_reg.address[OFFS_W-1:0]};
        dat_wr_en   = 1'b0;
        dat_wr_addr = {pt_rd_data.frame, item_reg.address[OFFS_W-1:0]};
        dat_wr_data = item_reg.write_data;

        emit      = 1'b0;
        emit_item = '0;
        old_valid = valid_reg[pidx];
        own_taken = owned_reg[fidx] && !(old_valid && (pt_rd_data.frame == fidx));

        // entry as stored, a never installed page reads as cleared
        ent = pt_rd_data;
        if (!init_reg[pidx])
        begin
            ent.ref_mark = 1'b0;
            ent.dirty    = 1'b0;
            ent.age      = '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    res_next  = '0;
                    state_next = ST_RESP;
                    if ((req.func == FN_READ) || (req.func == FN_WRITE))
                    begin
                        res_next.fault_page = vpage_in[PNUM_W-1:0];
                        if (!vpage_in_range)
                        begin
                            res_next.range_error = 1'b1;
                        end
                        else if (!valid_reg[vpage_in[PAGE_W-1:0]])
                        begin
                            res_next.fault = 1'b1;
                        end
                        else
                        begin
                            pt_rd_en   = 1'b1;
                            pt_rd_addr = vpage_in[PAGE_W-1:0];
                            state_next = ST_ACCESS;
                        end
                    end
                    else if (req.func == FN_INSTALL)
                    begin
                        if ((int'(req.page_idx) >= NUM_PAGES) ||
                            (int'(req.frame_number) >= NUM_FRAMES))
                        begin
                            res_next.range_error = 1'b1;
                        end
                        else
                        begin
                            pt_rd_en    = 1'b1;
                            pt_rd_addr  = req.page_idx[PAGE_W-1:0];
                            own_rd_en   = 1'b1;
                            own_rd_addr = req.frame_number[FRAME_W-1:0];
                            state_next  = ST_INSTALL;
                        end
                    end
                    else if ((req.func == FN_REMOVE) || (req.func == FN_QUERY))
                    begin
                        if (int'(req.page_idx) >= NUM_PAGES)
                        begin
                            res_next.range_error = 1'b1;
                        end
                        else
                        begin
                            pt_rd_en   = 1'b1;
                            pt_rd_addr = req.page_idx[PAGE_W-1:0];
                            state_next = ST_ENTRY;
                        end
                    end
                end
            end

            ST_ACCESS:
            begin
                pt_wr_addr          = vidx;
                pt_wr_data          = pt_rd_data;
                pt_wr_data.ref_mark = 1'b1;
                if (item_reg.func == FN_READ)
                begin
                    dat_rd_en    = 1'b1;
                    pt_wr_en     = 1'b1;
                    counter_next = cnt_hit ? '0 : cnt_inc[CNT_W-1:0];
                    aged_next    = aged_now;
                    state_next   = ST_READ_WAIT;
                end
                else if (out_free)
                begin
                    dat_wr_en            = 1'b1;
                    pt_wr_en             = 1'b1;
                    pt_wr_data.dirty     = 1'b1;
                    counter_next         = cnt_hit ? '0 : cnt_inc[CNT_W-1:0];
                    emit                 = 1'b1;
                    emit_item.fault_page = vpage_cur[PNUM_W-1:0];
                    emit_item.aged       = aged_now;
                    state_next           = aged_now ? ST_SWEEP : ST_IDLE;
                end
            end

            ST_READ_WAIT:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_item.read_data  = dat_rd_data;
                    emit_item.fault_page = vpage_cur[PNUM_W-1:0];
                    emit_item.aged       = aged_reg;
                    state_next           = aged_reg ? ST_SWEEP : ST_IDLE;
                end
            end

            ST_INSTALL:
            begin
                if (out_free)
                begin
                    // free the page's old frame, then unmap the frame's old page
                    if (old_valid)
                    begin
                        owned_next[pt_rd_data.frame] = 1'b0;
                    end
                    if (own_taken)
                    begin
                        valid_next[own_rd_data] = 1'b0;
                    end
                    valid_next[pidx] = 1'b1;
                    init_next[pidx]  = 1'b1;
                    owned_next[fidx] = 1'b1;
                    pt_wr_en         = 1'b1;
                    pt_wr_data       = '0;
                    pt_wr_data.frame = fidx;
                    own_wr_en        = 1'b1;
                    emit             = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            ST_ENTRY:
            begin
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_item.entry_valid = old_valid;
                    emit_item.entry_ref   = ent.ref_mark;
                    emit_item.entry_dirty = ent.dirty;
                    emit_item.entry_age   = ent.age;
                    if (item_reg.func == FN_REMOVE)
                    begin
                        if (old_valid)
                        begin
                            owned_next[pt_rd_data.frame] = 1'b0;
                        end
                        valid_next[pidx]    = 1'b0;
                        init_next[pidx]     = 1'b1;
                        pt_wr_en            = 1'b1;
                        pt_wr_data.ref_mark = 1'b0;
                        pt_wr_data.dirty    = 1'b0;
                        pt_wr_data.age      = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_item  = res_reg;
                    state_next = ST_IDLE;
                end
            end

            ST_SWEEP:
            begin
                // read one entry while the one before is written back
                pt_rd_en      = 1'b1;
                pt_rd_addr    = sweep_idx_reg;
                pend_next     = 1'b1;
                pend_idx_next = sweep_idx_reg;
                if (int'(sweep_idx_reg) == NUM_PAGES - 1)
                begin
                    sweep_idx_next = '0;
                    state_next     = ST_SWEEP_LAST;
                end
                else
                begin
                    sweep_idx_next = sweep_idx_reg + 1'b1;
                end
            end

            ST_SWEEP_LAST:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // aging write-back, only mapped pages move
        if (pend_reg && valid_reg[pend_idx_reg])
        begin
            pt_wr_en            = 1'b1;
            pt_wr_addr          = pend_idx_reg;
            pt_wr_data          = pt_rd_data;
            pt_wr_data.age      = {pt_rd_data.ref_mark, pt_rd_data.age[AGE_W-1:1]};
            pt_wr_data.ref_mark = 1'b0;
        end

        if (emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = emit_item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the paged access block with aging reference marks
`timescale 1ns / 100ps

module testbench;
    import pawa_pkg::*;

    localparam int HOLD_LEN   = 300;
    localparam int SETTLE     = 48;
    localparam int QUIET_MAX  = 3000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    in_item_t             req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    out_item_t            rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data  = '0;

    paged_access_with_aging_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    in_item_t    request_queue[$];
    out_item_t   predicted_results[$];
    out_item_t   want_rsp;
    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned tx_idle_pct    = 0;
    int unsigned rx_stall_pct   = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned hold_left      = 0;
    bit          hold_request   = 1'b0;
    bit          hold_seen      = 1'b0;

    // predicted page table, frame ownership and store
    logic [FRAME_W-1:0] pg_frame [NUM_PAGES];
    logic               pg_valid [NUM_PAGES];
    logic               pg_ref   [NUM_PAGES];
    logic               pg_dirty [NUM_PAGES];
    logic [AGE_W-1:0]   pg_age   [NUM_PAGES];
    logic [PAGE_W-1:0]  fr_owner [NUM_FRAMES];
    logic               fr_owned [NUM_FRAMES];
    logic [DATA_W-1:0]  store    [STORE_WORDS];
    logic [CNT_W-1:0]   acc_count;
    logic               model_aging_en;
    logic [CNT_W-1:0]   model_interval;

    // mapping as the stimulus generator sees it, ahead of acceptance
    logic [FRAME_W-1:0] gen_frame   [NUM_PAGES];
    logic               gen_mapped  [NUM_PAGES];
    logic [PAGE_W-1:0]  gen_owner   [NUM_FRAMES];
    logic               gen_owned   [NUM_FRAMES];
    logic               gen_written [STORE_WORDS];

    initial
    begin
        for (int i = 0; i < NUM_PAGES; i++)
        begin
            pg_frame[i]   = '0;
            pg_valid[i]   = 1'b0;
            pg_ref[i]     = 1'b0;
            pg_dirty[i]   = 1'b0;
            pg_age[i]     = '0;
            gen_frame[i]  = '0;
            gen_mapped[i] = 1'b0;
        end
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            fr_owner[i]  = '0;
            fr_owned[i]  = 1'b0;
            gen_owner[i] = '0;
            gen_owned[i] = 1'b0;
        end
        for (int i = 0; i < STORE_WORDS; i++)
        begin
            store[i]       = '0;
            gen_written[i] = 1'b0;
        end
        acc_count      = '0;
        model_aging_en = 1'b0;
        model_interval = AGE_INTERVAL_RST;
    end

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            mismatch_count++;
            $display("error at %0t: %0s got %0h want %0h", $time, what, got, want);
        end
    endtask

    // advance the access counter, sweeping the ages when the interval completes
    function automatic logic note_access();
        logic [PAGE_W-1:0] p;
        if ({1'b0, acc_count} + 17'd1 < {1'b0, model_interval})
        begin
            acc_count = acc_count + 1'b1;
            return 1'b0;
        end
        acc_count = '0;
        if (!model_aging_en)
            return 1'b0;
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            if (fr_owned[f])
            begin
                p = fr_owner[f];
                pg_age[p] = {pg_ref[p], pg_age[p][AGE_W-1:1]};
                pg_ref[p] = 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic out_item_t page_table_step(input in_item_t it);
        out_item_t          r;
        logic [VPAGE_W-1:0] vpage;
        logic [PAGE_W-1:0]  p;
        logic [LOC_W-1:0]   loc;
        r = '0;
        vpage = it.address[ADDR_W-1:OFFS_W];
        p = it.page_idx;
        case (it.func)
            FN_READ, FN_WRITE:
            begin
                r.fault_page = vpage[PAGE_W-1:0];
                if (vpage >= NUM_PAGES)
                    r.range_error = 1'b1;
                else if (!pg_valid[vpage[PAGE_W-1:0]])
                    r.fault = 1'b1;
                else
                begin
                    loc = {pg_frame[vpage[PAGE_W-1:0]], it.address[OFFS_W-1:0]};
                    pg_ref[vpage[PAGE_W-1:0]] = 1'b1;
                    if (it.func == FN_READ)
                        r.read_data = store[loc];
                    else
                    begin
                        pg_dirty[vpage[PAGE_W-1:0]] = 1'b1;
                        store[loc] = it.write_data;
                    end
                    r.aged = note_access();
                end
            end
            FN_INSTALL:
            begin
                if (pg_valid[p])
                    fr_owned[pg_frame[p]] = 1'b0;
                if (fr_owned[it.frame_number])
                    pg_valid[fr_owner[it.frame_number]] = 1'b0;
                pg_frame[p] = it.frame_number;
                pg_valid[p] = 1'b1;
                pg_ref[p]   = 1'b0;
                pg_dirty[p] = 1'b0;
                pg_age[p]   = '0;
                fr_owner[it.frame_number] = p;
                fr_owned[it.frame_number] = 1'b1;
            end
            FN_REMOVE, FN_QUERY:
            begin
                r.entry_valid = pg_valid[p];
                r.entry_ref   = pg_ref[p];
                r.entry_dirty = pg_dirty[p];
                r.entry_age   = pg_age[p];
                if (it.func == FN_REMOVE)
                begin
                    if (pg_valid[p])
                        fr_owned[pg_frame[p]] = 1'b0;
                    pg_valid[p] = 1'b0;
                    pg_ref[p]   = 1'b0;
                    pg_dirty[p] = 1'b0;
                    pg_age[p]   = '0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // a read of a word never written turns into a write of that word
    task automatic queue_item(input in_item_t it);
        logic [VPAGE_W-1:0] vp;
        logic [PAGE_W-1:0]  p;
        logic [LOC_W-1:0]   loc;
        vp = it.address[ADDR_W-1:OFFS_W];
        p = it.page_idx;
        case (it.func)
            FN_READ, FN_WRITE:
            begin
                if (vp < NUM_PAGES && gen_mapped[vp[PAGE_W-1:0]])
                begin
                    loc = {gen_frame[vp[PAGE_W-1:0]], it.address[OFFS_W-1:0]};
                    if (!gen_written[loc])
                        it.func = FN_WRITE;
                    gen_written[loc] = 1'b1;
                end
            end
            FN_INSTALL:
            begin
                if (gen_mapped[p])
                    gen_owned[gen_frame[p]] = 1'b0;
                if (gen_owned[it.frame_number])
                    gen_mapped[gen_owner[it.frame_number]] = 1'b0;
                gen_frame[p]  = it.frame_number;
                gen_mapped[p] = 1'b1;
                gen_owner[it.frame_number] = p;
                gen_owned[it.frame_number] = 1'b1;
            end
            FN_REMOVE:
            begin
                if (gen_mapped[p])
                    gen_owned[gen_frame[p]] = 1'b0;
                gen_mapped[p] = 1'b0;
            end
            default: ;
        endcase
        request_queue.push_back(it);
        queued_count++;
    endtask

    function automatic in_item_t make_item(input logic [FUNC_W-1:0] fn,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [DATA_W-1:0] data,
                                           input logic [PNUM_W-1:0] pnum,
                                           input logic [FNUM_W-1:0] fnum);
        in_item_t it;
        it.func         = fn;
        it.address      = addr;
        it.write_data   = data;
        it.page_idx     = pnum;
        it.frame_number = fnum;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned roll;
        int unsigned pg;
        it = make_item(FN_READ, ADDR_W'($urandom), DATA_W'($urandom), PNUM_W'($urandom),
                       FNUM_W'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 34)
            it.func = FN_READ;
        else if (roll < 64)
            it.func = FN_WRITE;
        else if (roll < 78)
            it.func = FN_INSTALL;
        else if (roll < 84)
            it.func = FN_REMOVE;
        else if (roll < 95)
            it.func = FN_QUERY;
        else
            it.func = FUNC_W'($urandom_range(5, 7));
        if ($urandom_range(0, 9) != 0)
        begin
            pg = $urandom_range(0, NUM_PAGES - 1);
            // steer most accesses towards a mapped page
            if ($urandom_range(0, 99) < 70)
            begin
                for (int i = 0; i < NUM_PAGES && !gen_mapped[pg]; i++)
                    pg = (pg + 1) % NUM_PAGES;
            end
            it.address = {VPAGE_W'(pg), OFFS_W'($urandom)};
        end
        return it;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predicted_results.push_back(page_table_step(req));
                accepted_count++;
            end
            if (req_valid && req_stall)
                ;
            else if (request_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                req_valid <= 1'b1;
                req       <= request_queue.pop_front();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_request && !hold_seen)
        begin
            hold_left <= HOLD_LEN;
            hold_seen <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_results.size() == 0)
                    check_field("result with nothing outstanding", 32'd1, 32'd0);
                else
                begin
                    want_rsp = predicted_results.pop_front();
                    check_field("read_data", rsp.read_data, want_rsp.read_data);
                    check_field("fault", 32'(rsp.fault), 32'(want_rsp.fault));
                    check_field("fault_page", 32'(rsp.fault_page),
                                32'(want_rsp.fault_page));
                    check_field("range_error", 32'(rsp.range_error),
                                32'(want_rsp.range_error));
                    check_field("entry_valid", 32'(rsp.entry_valid),
                                32'(want_rsp.entry_valid));
                    check_field("entry_ref", 32'(rsp.entry_ref), 32'(want_rsp.entry_ref));
                    check_field("entry_dirty", 32'(rsp.entry_dirty),
                                32'(want_rsp.entry_dirty));
                    check_field("entry_age", 32'(rsp.entry_age), 32'(want_rsp.entry_age));
                    check_field("aged", 32'(rsp.aged), 32'(want_rsp.aged));
                end
            end
            rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // watchdog on cycles with no transaction of any kind
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("paged_access_with_aging_core: mismatch");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_AGING_ENABLE)
            model_aging_en = val[0];
        else
            model_interval = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic en, input logic [CNT_W-1:0] interval);
        write_reg(CFG_AGING_ENABLE, CNT_W'(en));
        write_reg(CFG_AGE_INTERVAL, interval);
    endtask

    task automatic wait_drained();
        while (!(accepted_count == queued_count && predicted_results.size() == 0))
            @(negedge clk);
    endtask

    // a sweep may still run after the last result
    task automatic drain_and_settle();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_phase(input logic en, input logic [CNT_W-1:0] interval,
                                input int n, input int unsigned tx, input int unsigned rx);
        set_config(en, interval);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        repeat (n) queue_item(random_item());
        drain_and_settle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_config(1'b1, 16'd2);
        queue_item(make_item(FN_QUERY,   12'd0,    32'h0,         5'd0,  4'd0));
        queue_item(make_item(FN_READ,    12'd0,    32'h0,         5'd0,  4'd0));
        queue_item(make_item(FN_INSTALL, 12'd0,    32'h0,         5'd0,  4'd0));
        queue_item(make_item(FN_INSTALL, 12'd0,    32'h0,         5'd31, 4'd15));
        queue_item(make_item(FN_WRITE,   12'd0,    32'h8000_0000, 5'd0,  4'd0));
        queue_item(make_item(FN_WRITE,   12'd255,  32'h7fff_ffff, 5'd31, 4'd15));
        queue_item(make_item(FN_READ,    12'd0,    32'h0,         5'd0,  4'd0));
        queue_item(make_item(FN_READ,    12'd255,  32'hffff_ffff, 5'd31, 4'd15));
        // addresses beyond the virtual space
        queue_item(make_item(FN_READ,    12'd4095, 32'h0,         5'd0,  4'd0));
        queue_item(make_item(FN_WRITE,   12'd256,  32'h1234_5678, 5'd0,  4'd0));
        // taking frame 0 away from page 0
        queue_item(make_item(FN_INSTALL, 12'd0,    32'h0,         5'd5,  4'd0));
        queue_item(make_item(FN_READ,    12'd0,    32'h0,         5'd0,  4'd0));
        queue_item(make_item(FN_READ,    12'd40,   32'h0,         5'd5,  4'd0));
        // reinstall over a live mapping
        queue_item(make_item(FN_INSTALL, 12'd0,    32'h0,         5'd5,  4'd3));
        queue_item(make_item(FN_QUERY,   12'd0,    32'h0,         5'd5,  4'd0));
        queue_item(make_item(FN_WRITE,   12'd47,   32'hffff_ffff, 5'd5,  4'd3));
        queue_item(make_item(FN_QUERY,   12'd4095, 32'h0,         5'd5,  4'd15));
        queue_item(make_item(FN_REMOVE,  12'd0,    32'h0,         5'd5,  4'd0));
        queue_item(make_item(FN_REMOVE,  12'd0,    32'h0,         5'd5,  4'd0));
        queue_item(make_item(FN_QUERY,   12'd0,    32'h0,         5'd31, 4'd0));
        queue_item(make_item(3'd5,       12'd4095, 32'hffff_ffff, 5'd31, 4'd15));
        queue_item(make_item(3'd7,       12'd0,    32'h0,         5'd0,  4'd0));
        queue_item(make_item(FN_WRITE,   12'd0,    32'h0,         5'd0,  4'd0));
        drain_and_settle();

        random_phase(1'b1, 16'd0,     150, 0,  0);
        random_phase(1'b1, 16'd65535, 250, 56, 0);
        // interval now below the running count
        random_phase(1'b1, 16'd3,     250, 0,  56);
        random_phase(1'b0, 16'd1,     200, 19, 19);
        random_phase(1'b1, 16'd1,     150, 0,  0);

        // backlog: receiver held off while the sender keeps offering
        set_config(1'b1, 16'd7);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 1'b1;
        repeat (150) queue_item(random_item());
        drain_and_settle();

        // bursts with the sender waiting for every result in between
        set_config(1'b1, 16'd20);
        tx_idle_pct  = 19;
        rx_stall_pct = 19;
        repeat (10)
        begin
            repeat (20) queue_item(random_item());
            wait_drained();
        end
        repeat (SETTLE) @(posedge clk);

        random_phase(1'b1, 16'd5,     200, 56, 0);

        if (mismatch_count == 0)
            $display("paged_access_with_aging_core: match");
        else
            $display("paged_access_with_aging_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pawa_pkg.sv
rtl/core/pawa_ram.sv
rtl/core/pawa_ctrl.sv
rtl/core/paged_access_with_aging_core.sv
tb/testbench.sv
